[design/assert_macros.svh]
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define ASSERT_CLK_ANY(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/itoa_pkg.sv]
// Package: types, codes and constants of the integer to ASCII formatter
package itoa_pkg;

  localparam int MAX_DIGITS = 36;
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int BCD_DIGITS = 10;
  localparam int BUF_W = 4 * BCD_DIGITS;
  localparam int WORD_W = 32;
  localparam int CNT_W = $clog2(WORD_W);

  localparam logic [IDX_W-1:0] MAX_DIGITS_IDX = IDX_W'(MAX_DIGITS);
  localparam logic [IDX_W-1:0] DEC_DIGITS = IDX_W'(BCD_DIGITS);
  localparam logic [IDX_W-1:0] HEX_DIGITS = IDX_W'(WORD_W / 4);
  localparam logic [IDX_W-1:0] BIN_DIGITS = IDX_W'(WORD_W);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_UPPER_BASE = 8'h41 - 8'd10;
  localparam logic [7:0] CHAR_LOWER_BASE = 8'h61 - 8'd10;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  typedef enum logic [2:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_LHEX = 3'd2,
    OP_UHEX = 3'd3,
    OP_BIN  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_HEX,
    BASE_BIN
  } base_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_sign;
    logic emit_digit;
    logic skip;
  } dp_cmd_t;

  typedef struct packed {
    logic op_valid;
    logic op_dec;
    logic conv_last;
    logic neg;
    logic skip;
    logic index_zero;
  } dp_status_t;

endpackage

[design/itoa_ctrl.sv]
// Controller state machine of the integer to ASCII formatter
module itoa_ctrl import itoa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start && status.op_valid) begin
          cmd.load = 1'b1;
          state_next = status.op_dec ? ST_CONVERT : ST_EMIT;
        end
      end
      ST_CONVERT: begin
        cmd.conv_step = 1'b1;
        if (status.conv_last) begin
          state_next = status.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.skip) begin
          cmd.skip = 1'b1;
        end else begin
          cmd.emit_digit = 1'b1;
          if (status.index_zero) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/itoa_datapath.sv]
// Datapath: pad register, BCD conversion, digit buffer and character output
module itoa_datapath import itoa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pad_width_we,
  input  logic [5:0]  pad_width,
  input  logic [31:0] value,
  input  logic [2:0]  operation,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        strobe,
  output logic [7:0]  character,
  output logic        last
);

  logic [5:0]       pad_cfg;
  logic [IDX_W-1:0] pad_clamped;
  logic [WORD_W-1:0] mag;
  logic [BUF_W-1:0] digits;
  logic [BUF_W-1:0] digits_adj;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] index;
  logic [IDX_W-1:0] base_digits;
  logic [IDX_W-1:0] width_sel;
  base_t            base;
  logic             upper;
  logic             neg;
  logic             started;
  logic             in_neg;
  logic [3:0]       digit;
  logic [7:0]       digit_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_cfg <= '0;
    end else if (pad_width_we) begin
      pad_cfg <= pad_width;
    end
  end

  assign pad_clamped = (IDX_W'(pad_cfg) > MAX_DIGITS_IDX) ? MAX_DIGITS_IDX : IDX_W'(pad_cfg);

  assign in_neg = (operation == OP_SDEC) && value[WORD_W-1];

  always_comb begin
    case (operation)
      OP_SDEC, OP_UDEC: base_digits = DEC_DIGITS;
      OP_LHEX, OP_UHEX: base_digits = HEX_DIGITS;
      default:          base_digits = BIN_DIGITS;
    endcase
    width_sel = (pad_clamped > base_digits) ? pad_clamped : base_digits;
  end

  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      digits_adj[4*d +: 4] = (digits[4*d +: 4] >= 4'd5) ? digits[4*d +: 4] + 4'd3
                                                       : digits[4*d +: 4];
    end
  end

  always_comb begin
    digit = 4'd0;
    case (base)
      BASE_DEC: if (index < DEC_DIGITS) digit = digits[{index[3:0], 2'b00} +: 4];
      BASE_HEX: if (index < HEX_DIGITS) digit = digits[{index[2:0], 2'b00} +: 4];
      BASE_BIN: if (index < BIN_DIGITS) digit = {3'b000, digits[index[4:0]]};
      default:  digit = 4'd0;
    endcase
    if (digit < 4'd10) begin
      digit_char = CHAR_ZERO + 8'(digit);
    end else begin
      digit_char = (upper ? CHAR_UPPER_BASE : CHAR_LOWER_BASE) + 8'(digit);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg   <= in_neg;
      upper <= (operation == OP_UHEX);
      index <= width_sel - IDX_W'(1);
      cnt   <= '0;
      mag   <= in_neg ? (WORD_W'(0) - value) : value;
      if (operation inside {OP_SDEC, OP_UDEC}) begin
        base   <= BASE_DEC;
        digits <= '0;
      end else begin
        base   <= (operation == OP_BIN) ? BASE_BIN : BASE_HEX;
        digits <= BUF_W'(value);
      end
    end else if (cmd.conv_step) begin
      digits <= {digits_adj[BUF_W-2:0], mag[WORD_W-1]};
      mag    <= {mag[WORD_W-2:0], 1'b0};
      cnt    <= cnt + CNT_W'(1);
    end else if (cmd.emit_digit || cmd.skip) begin
      index <= index - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign || cmd.emit_digit;
      if (cmd.load) begin
        started <= 1'b0;
      end else if (cmd.emit_digit) begin
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= digit_char;
      last      <= (index == '0);
    end
  end

  always_comb begin
    status.op_valid   = operation inside {OP_SDEC, OP_UDEC, OP_LHEX, OP_UHEX, OP_BIN};
    status.op_dec     = operation inside {OP_SDEC, OP_UDEC};
    status.conv_last  = (cnt == CNT_W'(WORD_W - 1));
    status.neg        = neg;
    status.index_zero = (index == '0);
    status.skip       = !started && (index >= pad_clamped) && (digit == 4'd0) &&
                        (index != '0);
  end

endmodule

[design/integer_to_ascii_formatter_core.sv]
// Top level of the integer to ASCII formatter
// Takes a 32-bit word on start (when busy is low) and emits its ASCII characters, most
// significant first, one per strobe cycle, with last on the final one; the receiver
// cannot stall, so every strobe beat must be taken. Decimal formats first convert the
// word to BCD by shifting it in bit by bit; every format then walks the digit buffer
// from the top position (the larger of pad width and 10, 8 or 32 digits) down, one
// position at a time, dropping leading zeros above the pad width. A negative signed
// decimal value is preceded by a minus sign. Operation codes 5 to 7 are ignored and
// give no characters. The user must write pad_width with pad_width_we only while idle;
// the block itself does not enforce this. Values above 36 act as 36.
module integer_to_ascii_formatter_core import itoa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pad_width_we,
  input  logic [5:0]  pad_width,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value,
  input  logic [2:0]  operation,
  output logic        strobe,
  output logic [7:0]  character,
  output logic        last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  itoa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  itoa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .pad_width_we (pad_width_we),
    .pad_width    (pad_width),
    .value        (value),
    .operation    (operation),
    .cmd          (cmd),
    .status       (status),
    .strobe       (strobe),
    .character    (character),
    .last         (last)
  );

endmodule

[design/itoa_checker.sv]
// Port-level assertions for the integer to ASCII formatter, bound to the top level
`include "assert_macros.svh"

module itoa_checker import itoa_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [2:0] operation,
  input logic       strobe,
  input logic [7:0] character,
  input logic       last
);

  `ASSERT_CLK_ANY(a_reset_idle, rst |=> (!busy && !strobe), "block not idle after reset")
  `ASSERT_CLK(a_gap_after_last, (strobe && last) |=> !strobe, "beat right after last beat")
  `ASSERT_CLK(a_minus_not_last, (strobe && character == CHAR_MINUS) |-> !last, "minus last")
  `ASSERT_CLK(a_busy_on_accept, (start && !busy && operation <= OP_BIN) |=> busy, "not busy")

endmodule

bind integer_to_ascii_formatter_core itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .strobe    (strobe),
  .character (character),
  .last      (last)
);

[verif/tb_top.sv]
// Testbench for integer_to_ascii_formatter_core: queued numbers in, predicted characters checked
`timescale 1ns / 100ps

module tb_top;
  import itoa_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 19;
  localparam int MAX_SHOWN = 30;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  op;
  } number_t;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } char_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pad_width_we = 1'b0;
  logic [5:0]  pad_width = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] value = '0;
  logic [2:0]  operation = '0;
  logic        strobe;
  logic [7:0]  character;
  logic        last;

  number_t    number_queue[$];
  char_beat_t pending_chars[$];
  logic [5:0] pad_copy = '0;
  logic [5:0] pad_plan [10] = '{6'd36, 6'd63, 6'd1, 6'd10, 6'd37, 6'd32, 6'd8, 6'd20,
                                6'd0, 6'd0};
  bit         idle_on = 1'b1;
  int         gap_left = 0;
  int         items_pushed = 0;
  int         items_taken = 0;
  int         chars_seen = 0;
  int         quiet = 0;
  int         error_count = 0;
  int         pad_settings = 0;
  number_t    nxt;
  char_beat_t exp_beat;

  integer_to_ascii_formatter_core DUT (
    .clk          (clk),
    .rst          (rst),
    .pad_width_we (pad_width_we),
    .pad_width    (pad_width),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .operation    (operation),
    .strobe       (strobe),
    .character    (character),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (error_count < MAX_SHOWN) $display("ERROR @%0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic void format_number(input logic [31:0] word, input logic [2:0] op,
                                        input logic [5:0] pad_cfg);
    logic [31:0] mag;
    logic [31:0] radix;
    logic        upper;
    logic        minus;
    logic [4:0]  digs [MAX_DIGITS];
    int          n;
    int          width;
    char_beat_t  b;
    upper = 1'b0;
    minus = 1'b0;
    radix = 32'd10;
    n = 0;
    mag = word;
    case (op)
      OP_SDEC, OP_UDEC: radix = 32'd10;
      OP_LHEX: radix = 32'd16;
      OP_UHEX: begin
        radix = 32'd16;
        upper = 1'b1;
      end
      OP_BIN: radix = 32'd2;
      default: return;
    endcase
    if (op == OP_SDEC && word[31]) begin
      minus = 1'b1;
      mag = -word;
    end
    for (int i = 0; i < MAX_DIGITS; i++) digs[i] = '0;
    while (mag != 0 && n < MAX_DIGITS) begin
      digs[n] = 5'(mag % radix);
      mag = mag / radix;
      n++;
    end
    width = (pad_cfg > MAX_DIGITS) ? MAX_DIGITS : int'(pad_cfg);
    if (n > width) width = n;
    if (width == 0) width = 1;
    if (minus) begin
      b.ch = CHAR_MINUS;
      b.fin = 1'b0;
      pending_chars.push_back(b);
    end
    for (int i = width - 1; i >= 0; i--) begin
      if (digs[i] < 10) b.ch = CHAR_ZERO + 8'(digs[i]);
      else b.ch = (upper ? CHAR_UPPER_BASE : CHAR_LOWER_BASE) + 8'(digs[i]);
      b.fin = (i == 0);
      pending_chars.push_back(b);
    end
  endfunction

  function automatic logic [31:0] random_word();
    int k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 999));
      1: return 32'd1 << k;
      2: return (32'd1 << k) - 32'd1;
      3: return 32'h8000_0000 | 32'($urandom_range(0, 15));
      4: return -32'($urandom_range(1, 1000));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_number(input logic [31:0] word, input logic [2:0] op);
    number_t it;
    it.word = word;
    it.op = op;
    number_queue.push_back(it);
    items_pushed++;
  endtask

  task automatic set_pad(input logic [5:0] w);
    @(posedge clk);
    pad_width_we <= 1'b1;
    pad_width <= w;
    pad_copy = w;
    pad_settings++;
    @(posedge clk);
    pad_width_we <= 1'b0;
  endtask

  task automatic drain();
    while (items_taken != items_pushed || pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // driver: present the next number once the previous number is taken and its gap has passed
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        format_number(value, operation, pad_copy);
        items_taken++;
        gap_left = idle_on ? $urandom_range(0, 17) : 0;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (number_queue.size() != 0) begin
          nxt = number_queue.pop_front();
          value <= nxt.word;
          operation <= nxt.op;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst && strobe) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character %h with none expected", character));
      end else begin
        exp_beat = pending_chars.pop_front();
        if (character !== exp_beat.ch)
          report_mismatch($sformatf("character %h, expected %h", character, exp_beat.ch));
        if (last !== exp_beat.fin)
          report_mismatch($sformatf("last %b, expected %b", last, exp_beat.fin));
      end
    end
    if ((start && !busy) || strobe) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("integer_to_ascii_formatter_core: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_pad(6'd0);
    for (int op = 0; op <= 4; op++) begin
      queue_number(32'd0, 3'(op));
      queue_number(32'hFFFF_FFFF, 3'(op));
    end
    queue_number(32'h8000_0000, OP_SDEC);
    queue_number(32'h8000_0000, OP_UDEC);
    queue_number(32'h8000_0000, OP_BIN);
    queue_number(32'h7FFF_FFFF, OP_SDEC);
    queue_number(32'd1, OP_SDEC);
    queue_number(32'd9, OP_UDEC);
    queue_number(32'd10, OP_UDEC);
    queue_number(32'h1234_5678, OP_LHEX);
    queue_number(32'hABCD_EF09, OP_LHEX);
    queue_number(32'hABCD_EF09, OP_UHEX);
    queue_number(32'hDEAD_BEEF, OP_UHEX);
    queue_number($urandom, 3'd5);
    queue_number($urandom, 3'd6);
    queue_number($urandom, 3'd7);
    drain();
    pad_plan[8] = 6'($urandom_range(0, 63));
    pad_plan[9] = 6'($urandom_range(0, 63));
    for (int p = 0; p < 10; p++) begin
      set_pad(pad_plan[p]);
      idle_on = (p % 3 != 2);
      queue_number(32'd0, 3'($urandom_range(0, 4)));
      queue_number(32'h8000_0000, OP_SDEC);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if ($urandom_range(0, 9) < 9) queue_number(random_word(), 3'($urandom_range(0, 4)));
        else queue_number(random_word(), 3'($urandom_range(5, 7)));
      end
      drain();
    end
    $display("covered %0d numbers in all five formats plus unused codes", items_taken);
    $display("checked %0d characters across %0d pad settings", chars_seen, pad_settings);
    if (error_count == 0) begin
      $display("integer_to_ascii_formatter_core: match");
    end else begin
      $display("%0d mismatches", error_count);
      $display("integer_to_ascii_formatter_core: mismatch");
    end
    $finish;
  end

endmodule
